// ===== sv/brrg_pkg.sv =====
package brrg_pkg;

    // One 128-bit ring block as four 32-bit words, word 0 least significant
    typedef logic [3:0][31:0] block_t;

    // Request kinds carried on the input tuser
    localparam logic [1:0] OP_RESEED  = 2'd0;
    localparam logic [1:0] OP_DRAW32  = 2'd1;
    localparam logic [1:0] OP_DRAW64  = 2'd2;
    localparam logic [1:0] OP_DRAW128 = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTNER_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_LEFT_SHIFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LEFT_SHIFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_RIGHT_SHIFT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_WORD0       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_WORD1       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_WORD2       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_WORD3       = 3'd7;

    // Register reset values
    localparam logic [7:0]  RST_PARTNER_OFFSET   = 8'd1;
    localparam logic [4:0]  RST_WORD_LEFT_SHIFT  = 5'd11;
    localparam logic [2:0]  RST_BYTE_LEFT_SHIFT  = 3'd1;
    localparam logic [4:0]  RST_WORD_RIGHT_SHIFT = 5'd7;
    localparam logic [31:0] RST_MASK_WORD        = 32'd7;

    // Seeding recurrence constants
    localparam logic [31:0] SEED_MULT  = 32'd1812433253;
    localparam int unsigned SEED_SHIFT = 30;

    // Block recurrence: new value of block a from partner b and previous block c
    function automatic block_t refresh_block(
        input block_t      a,
        input block_t      b,
        input block_t      c,
        input logic [2:0]  byte_sl,
        input logic [4:0]  word_sl,
        input logic [4:0]  word_sr,
        input block_t      masks
    );
        block_t x;
        block_t r;
        x = a << {byte_sl, 3'b000};
        for (int k = 0; k < 4; k++) begin
            r[k] = a[k] ^ x[k] ^ (b[(k + 1) % 4] & masks[k]) ^ (b[k] << word_sl)
                 ^ c[k] ^ (c[k] >> word_sr);
        end
        return r;
    endfunction

endpackage

// ===== sv/block_recurrence_random_generator_top.sv =====
// Block-recurrence random generator over a ring of RING_BLOCKS 128-bit blocks held in
// a single-write, single-read block RAM. Operation 0 (tuser) reseeds the ring from the
// 32-bit seed in tdata, one word per cycle through one 32x32 multiplier. Draws of 32,
// 64 or 128 bits return the words at the current index; when the index sits on a block
// boundary the block is first refreshed from three sequential RAM reads (current,
// partner, previous block) and one write; a draw inside a block only reads the block,
// and a misaligned 64- or 128-bit draw returns zero data with the tuser flag set. In
// every case the result turns valid in the same cycle as the next request can be
// accepted, and a result held back by m_tready stalls the result stage. One request
// is in flight at a time; the next is accepted while the previous result waits in the
// output register.
// Configuration writes must only be issued while idle. Drawing before the first reseed
// returns undefined data.
module block_recurrence_random_generator_top #(
    parameter int RING_BLOCKS = 156
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [brrg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [brrg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,  // [31:0] seed
    input  logic [1:0]                       s_tuser,  // [1:0] operation
    // Result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [127:0]                     m_tdata,  // [63:0] rand_low, [127:64] rand_high
    output logic                             m_tuser   // [0] misaligned
);
    import brrg_pkg::*;

    localparam int BW = $clog2(RING_BLOCKS);
    localparam int IW = BW + 2;
    localparam int SW = BW + 9;
    localparam int RING_WORDS = 4 * RING_BLOCKS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SEED = 4'd1;
    localparam logic [3:0] S_RA   = 4'd2;
    localparam logic [3:0] S_RB   = 4'd3;
    localparam logic [3:0] S_RC   = 4'd4;
    localparam logic [3:0] S_CALC = 4'd5;
    localparam logic [3:0] S_RD   = 4'd6;
    localparam logic [3:0] S_RDW  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    // Configuration registers
    logic [7:0]  partner_offset_reg;
    logic [4:0]  word_left_shift_reg;
    logic [2:0]  byte_left_shift_reg;
    logic [4:0]  word_right_shift_reg;
    block_t      masks_reg;

    // Sequencer and datapath registers
    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] word_index_reg, word_index_next;
    logic [1:0]    op_reg, op_next;
    logic          zero_reg, zero_next;
    logic          bad_reg, bad_next;
    logic [31:0]   prev_reg, prev_next;
    logic [IW-1:0] seed_cnt_reg, seed_cnt_next;
    block_t        seed_buf_reg, seed_buf_next;
    logic [BW-1:0] b_idx_reg, b_idx_next;
    block_t        a_reg, a_next;
    block_t        b_reg, b_next;
    block_t        blk_reg, blk_next;
    logic          out_valid_reg, out_valid_next;
    logic [63:0]   out_low_reg, out_low_next;
    logic [63:0]   out_high_reg, out_high_next;
    logic          out_bad_reg, out_bad_next;

    // Memory port signals
    logic          ram_we;
    logic [BW-1:0] ram_waddr;
    block_t        ram_wdata;
    logic [BW-1:0] ram_raddr;
    logic [127:0]  ram_rdata;

    // Combinational helpers
    logic [BW-1:0] cur_blk;
    logic [BW-1:0] c_idx;
    logic [SW-1:0] mod_acc;
    logic [31:0]   seed_mix;
    logic [31:0]   seed_word;
    block_t        refreshed;
    logic          out_free;
    logic [IW:0]   index_sum;

    assign cur_blk  = word_index_reg[IW-1:2];
    assign c_idx    = (cur_blk == '0) ? BW'(RING_BLOCKS - 1) : cur_blk - BW'(1);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Reduce block + partner offset modulo the ring size by restoring subtraction
    always_comb begin
        mod_acc = SW'(cur_blk) + SW'(partner_offset_reg);
        for (int k = 7; k >= 0; k--) begin
            if (mod_acc >= (SW'(RING_BLOCKS) << k)) begin
                mod_acc = mod_acc - (SW'(RING_BLOCKS) << k);
            end
        end
    end

    // Next seed word from the previous one
    assign seed_mix  = prev_reg ^ (prev_reg >> SEED_SHIFT);
    assign seed_word = SEED_MULT * seed_mix + 32'(seed_cnt_reg);

    // Refreshed block once the previous block arrives from the RAM
    assign refreshed = refresh_block(a_reg, b_reg, block_t'(ram_rdata), byte_left_shift_reg,
                                     word_left_shift_reg, word_right_shift_reg, masks_reg);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partner_offset_reg   <= RST_PARTNER_OFFSET;
            word_left_shift_reg  <= RST_WORD_LEFT_SHIFT;
            byte_left_shift_reg  <= RST_BYTE_LEFT_SHIFT;
            word_right_shift_reg <= RST_WORD_RIGHT_SHIFT;
            masks_reg            <= {4{RST_MASK_WORD}};
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PARTNER_OFFSET:   partner_offset_reg   <= cfg_wdata[7:0];
                CFG_WORD_LEFT_SHIFT:  word_left_shift_reg  <= cfg_wdata[4:0];
                CFG_BYTE_LEFT_SHIFT:  byte_left_shift_reg  <= cfg_wdata[2:0];
                CFG_WORD_RIGHT_SHIFT: word_right_shift_reg <= cfg_wdata[4:0];
                CFG_MASK_WORD0:       masks_reg[0]         <= cfg_wdata;
                CFG_MASK_WORD1:       masks_reg[1]         <= cfg_wdata;
                CFG_MASK_WORD2:       masks_reg[2]         <= cfg_wdata;
                CFG_MASK_WORD3:       masks_reg[3]         <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        word_index_next = word_index_reg;
        op_next         = op_reg;
        zero_next       = zero_reg;
        bad_next        = bad_reg;
        prev_next       = prev_reg;
        seed_cnt_next   = seed_cnt_reg;
        seed_buf_next   = seed_buf_reg;
        b_idx_next      = b_idx_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        blk_next        = blk_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_low_next    = out_low_reg;
        out_high_next   = out_high_reg;
        out_bad_next    = out_bad_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_blk;
        ram_wdata       = refreshed;
        ram_raddr       = cur_blk;
        index_sum       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next   = s_tuser;
                    zero_next = 1'b0;
                    bad_next  = 1'b0;
                    unique case (s_tuser)
                        OP_RESEED: begin
                            prev_next       = s_tdata;
                            seed_buf_next   = '0;
                            seed_buf_next[0] = s_tdata;
                            seed_cnt_next   = IW'(1);
                            state_next      = S_SEED;
                        end
                        OP_DRAW32: begin
                            state_next = (word_index_reg[1:0] == 2'b00) ? S_RA : S_RD;
                        end
                        OP_DRAW64: begin
                            if (word_index_reg[0]) begin
                                zero_next  = 1'b1;
                                bad_next   = 1'b1;
                                state_next = S_OUT;
                            end else begin
                                state_next = (word_index_reg[1:0] == 2'b00) ? S_RA : S_RD;
                            end
                        end
                        OP_DRAW128: begin
                            if (word_index_reg[1:0] != 2'b00) begin
                                zero_next  = 1'b1;
                                bad_next   = 1'b1;
                                state_next = S_OUT;
                            end else begin
                                state_next = S_RA;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Generate one seed word per cycle, write each completed block
            S_SEED: begin
                prev_next = seed_word;
                seed_buf_next[seed_cnt_reg[1:0]] = seed_word;
                if (seed_cnt_reg[1:0] == 2'b11) begin
                    ram_we    = 1'b1;
                    ram_waddr = seed_cnt_reg[IW-1:2];
                    ram_wdata = {seed_word, seed_buf_reg[2], seed_buf_reg[1], seed_buf_reg[0]};
                end
                seed_cnt_next = seed_cnt_reg + IW'(1);
                if (seed_cnt_reg == IW'(RING_WORDS - 1)) begin
                    word_index_next = '0;
                    zero_next       = 1'b1;
                    state_next      = S_OUT;
                end
            end
            // Fetch current block, work out the partner index
            S_RA: begin
                ram_raddr  = cur_blk;
                b_idx_next = mod_acc[BW-1:0];
                state_next = S_RB;
            end
            S_RB: begin
                ram_raddr  = b_idx_reg;
                a_next     = block_t'(ram_rdata);
                state_next = S_RC;
            end
            S_RC: begin
                ram_raddr  = c_idx;
                b_next     = block_t'(ram_rdata);
                state_next = S_CALC;
            end
            // Combine and write back the refreshed block
            S_CALC: begin
                ram_we     = 1'b1;
                ram_waddr  = cur_blk;
                ram_wdata  = refreshed;
                blk_next   = refreshed;
                state_next = S_OUT;
            end
            S_RD: begin
                ram_raddr  = cur_blk;
                state_next = S_RDW;
            end
            S_RDW: begin
                blk_next   = block_t'(ram_rdata);
                state_next = S_OUT;
            end
            // Load the result register and advance the index
            S_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_bad_next   = bad_reg;
                    out_low_next   = '0;
                    out_high_next  = '0;
                    if (!zero_reg) begin
                        unique case (op_reg)
                            OP_DRAW32: begin
                                out_low_next = {32'd0, blk_reg[word_index_reg[1:0]]};
                                index_sum    = {1'b0, word_index_reg} + (IW + 1)'(1);
                            end
                            OP_DRAW64: begin
                                out_low_next = word_index_reg[1] ? {blk_reg[3], blk_reg[2]}
                                                                 : {blk_reg[1], blk_reg[0]};
                                index_sum    = {1'b0, word_index_reg} + (IW + 1)'(2);
                            end
                            default: begin
                                out_low_next  = {blk_reg[1], blk_reg[0]};
                                out_high_next = {blk_reg[3], blk_reg[2]};
                                index_sum     = {1'b0, word_index_reg} + (IW + 1)'(4);
                            end
                        endcase
                        word_index_next = (index_sum >= (IW + 1)'(RING_WORDS)) ? '0
                                                                          : index_sum[IW-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            word_index_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            word_index_reg <= word_index_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        zero_reg     <= zero_next;
        bad_reg      <= bad_next;
        prev_reg     <= prev_next;
        seed_cnt_reg <= seed_cnt_next;
        seed_buf_reg <= seed_buf_next;
        b_idx_reg    <= b_idx_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        blk_reg      <= blk_next;
        out_low_reg  <= out_low_next;
        out_high_reg <= out_high_next;
        out_bad_reg  <= out_bad_next;
    end

    brrg_ram #(
        .WIDTH (128),
        .DEPTH (RING_BLOCKS)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_high_reg, out_low_reg};
    assign m_tuser  = out_bad_reg;

`ifndef SYNTHESIS
    a_index_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        word_index_reg < IW'(RING_WORDS))
        else $error("word index left the ring");

    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_SEED || state_reg == S_CALC))
        else $error("ring written outside seeding or refresh");

    a_misaligned_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("misaligned result carries data");

    a_calc_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CALC) |=> (state_reg == S_OUT))
        else $error("refresh not followed by result stage");

    a_index_hold_misaligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && bad_reg && out_free) |=> $stable(word_index_reg))
        else $error("misaligned draw moved the index");
`endif

endmodule

// ===== sv/brrg_ram.sv =====
module brrg_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 156
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
